// ----- hdl/byte_code_cpu_step_unit_defines.svh -----
// assertion macros for the byte code cpu step unit
// used by the rtl files that carry concurrent checks; needs clk_i and rst_ni in scope
`ifndef BYTE_CODE_CPU_STEP_UNIT_DEFINES_SVH
`define BYTE_CODE_CPU_STEP_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define BCCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define BCCS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define BCCS_ASSERT(lbl, prop, msg)
`define BCCS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- hdl/bccs_pkg.sv -----
// shared types, opcodes and status codes of the byte code cpu step unit
// no dependencies; imported by the alu and the top level
`default_nettype none
package bccs_pkg;

  localparam logic [7:0] OP_NOP   = 8'd0;
  localparam logic [7:0] OP_MOV   = 8'd1;
  localparam logic [7:0] OP_INC   = 8'd2;
  localparam logic [7:0] OP_DEC   = 8'd3;
  localparam logic [7:0] OP_JMP   = 8'd4;
  localparam logic [7:0] OP_CALL  = 8'd5;
  localparam logic [7:0] OP_ADD   = 8'd6;
  localparam logic [7:0] OP_SUB   = 8'd7;
  localparam logic [7:0] OP_PUSH  = 8'd8;
  localparam logic [7:0] OP_POP   = 8'd9;
  localparam logic [7:0] OP_PRT   = 8'd10;
  localparam logic [7:0] OP_STOP  = 8'd11;
  localparam logic [7:0] OP_MOVM  = 8'd12;
  localparam logic [7:0] OP_CMP   = 8'd13;
  localparam logic [7:0] OP_JEQ   = 8'd14;
  localparam logic [7:0] OP_MOVR  = 8'd15;
  localparam logic [7:0] OP_MOVMR = 8'd16;

  localparam logic [2:0] ST_RUN   = 3'd0;
  localparam logic [2:0] ST_STOP  = 3'd1;
  localparam logic [2:0] ST_IPOOB = 3'd2;
  localparam logic [2:0] ST_BADOP = 3'd3;
  localparam logic [2:0] ST_ABORT = 3'd4;

  localparam logic [2:0] FL_EQ = 3'd1;
  localparam logic [2:0] FL_LT = 3'd2;
  localparam logic [2:0] FL_GT = 3'd4;

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_EXEC = 2'd1;
  localparam logic [1:0] MODE_RDB  = 2'd2;
  localparam logic [1:0] MODE_RDR  = 2'd3;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic        sub;
  } alu_req_t;

  typedef struct packed {
    logic [32:0] sum;
    logic        eq;
    logic        gt;
  } alu_res_t;

  function automatic logic [2:0] op_len(input logic [7:0] op);
    logic [2:0] l;
    case (op)
      OP_MOV, OP_MOVM:                          l = 3'd6;
      OP_JMP, OP_PUSH, OP_JEQ:                  l = 3'd5;
      OP_ADD, OP_SUB, OP_CMP, OP_MOVR, OP_MOVMR: l = 3'd3;
      OP_INC, OP_DEC, OP_POP, OP_PRT:           l = 3'd2;
      default:                                  l = 3'd1;
    endcase
    return l;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/bccs_alu.sv -----
// shared 32-bit add, subtract and unsigned compare unit
// depends on bccs_pkg for the request and result structs
`default_nettype none
module bccs_alu (
  input  bccs_pkg::alu_req_t req_i,
  output bccs_pkg::alu_res_t res_o
);
  import bccs_pkg::*;

  always_comb begin
    if (req_i.sub) begin
      res_o.sum = {1'b0, req_i.a} - {1'b0, req_i.b};
    end else begin
      res_o.sum = {1'b0, req_i.a} + {1'b0, req_i.b};
    end
    res_o.eq = (req_i.a == req_i.b);
    res_o.gt = (req_i.a > req_i.b);
  end

endmodule
`default_nettype wire

// ----- hdl/bccs_mem.sv -----
// single port byte memory with registered read data
// no dependencies
`default_nettype none
module bccs_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] addr_i,
  input  wire logic [7:0]    wdata_i,
  output logic      [7:0]    rdata_o
);
  logic [7:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule
`default_nettype wire

// ----- hdl/byte_code_cpu_step_unit.sv -----
// byte code cpu step unit: one request in, one result out, sequenced over a byte memory.
// after reset all MEM_BYTES bytes of memory are cleared, one byte a cycle, before any request.
// load and register read go straight to the result; a byte read adds the registered read.
// execute: bytewise fetch, read ra, rb and sp, alu; for push, pop, movm and movmr a bounds
// check and a word store or load over the single byte-wide port; then ip, dest and sp writes.
// one request at a time. depends on bccs_pkg, bccs_alu, bccs_mem and the defines header
`default_nettype none
`include "byte_code_cpu_step_unit_defines.svh"
module byte_code_cpu_step_unit #(
  parameter int MEM_BYTES = 4096,
  parameter int IP_REG    = 15,
  parameter int SP_REG    = 14
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  mode_i,
  input  wire logic [11:0] address_i,
  input  wire logic [7:0]  data_i,
  input  wire logic [3:0]  reg_index_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      read_value_o,
  output logic [31:0]      ip_now_o,
  output logic [2:0]       machine_status_o,
  output logic [2:0]       cmp_flags_o
);
  import bccs_pkg::*;

  localparam int AW = $clog2(MEM_BYTES);
  localparam logic [3:0] IP_SEL = 4'(IP_REG);
  localparam logic [3:0] SP_SEL = 4'(SP_REG);
  localparam logic [32:0] MEM_LIM = 33'(MEM_BYTES);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_RDW, S_FREQ, S_FCAP, S_RA, S_RB, S_RS, S_XALU, S_XCHK,
    S_MST, S_MLREQ, S_MLCAP, S_WIP, S_WRA, S_WSP, S_RESP
  } state_e;

  state_e      state_q;
  logic [AW-1:0] clr_q;
  logic [2:0]  cnt_q;
  logic [2:0]  len_q;
  logic [7:0]  buf_q [6];
  logic [31:0] ip_q, next_q, va_q, vb_q, sp_q, res_q, waddr_q, sword_q, word_q, rv_q;
  logic [2:0]  status_q, flags_q;
  logic [31:0] rf_q [16];

  logic        accept;
  logic [3:0]  rf_rsel, rf_wsel;
  logic        rf_we;
  logic [31:0] rf_wdata, rf_rd;
  logic        mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]  mem_wdata, mem_rdata;
  alu_req_t    alu_req;
  alu_res_t    alu_res;
  logic [7:0]  op;
  logic [3:0]  ra, rb;
  logic [31:0] imm, jimm, addr_ext;
  logic        addr_ok, ra_write;
  logic [2:0]  flen;

  bccs_alu u_alu (
    .req_i (alu_req),
    .res_o (alu_res)
  );

  bccs_mem #(
    .DEPTH (MEM_BYTES),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign op         = buf_q[0];
  assign ra         = buf_q[1][3:0];
  assign rb         = buf_q[2][3:0];
  assign imm        = {buf_q[2], buf_q[3], buf_q[4], buf_q[5]};
  assign jimm       = {buf_q[1], buf_q[2], buf_q[3], buf_q[4]};
  assign addr_ext   = {20'd0, address_i};
  assign addr_ok    = ({1'b0, addr_ext} < MEM_LIM);
  assign rf_rd      = rf_q[rf_rsel];
  assign flen       = op_len(mem_rdata);
  assign ra_write   = (op == OP_MOV) || (op == OP_INC) || (op == OP_DEC) ||
                      (op == OP_ADD) || (op == OP_SUB) || (op == OP_POP) ||
                      (op == OP_MOVR);

  always_comb begin
    rf_rsel   = IP_SEL;
    rf_we     = 1'b0;
    rf_wsel   = IP_SEL;
    rf_wdata  = next_q;
    mem_we    = 1'b0;
    mem_addr  = clr_q;
    mem_wdata = 8'd0;
    alu_req   = '0;
    case (state_q)
      S_CLR: begin
        mem_we = 1'b1;
      end
      S_IDLE: begin
        mem_addr = addr_ext[AW-1:0];
        if (mode_i == MODE_RDR) begin
          rf_rsel = reg_index_i;
        end
        mem_we    = accept && (mode_i == MODE_LOAD) && addr_ok;
        mem_wdata = data_i;
      end
      S_FREQ: begin
        mem_addr = ip_q[AW-1:0] + AW'(cnt_q);
      end
      S_RA: rf_rsel = ra;
      S_RB: rf_rsel = rb;
      S_RS: rf_rsel = SP_SEL;
      S_XALU: begin
        case (op)
          OP_INC:  alu_req = '{a: va_q, b: 32'd1, sub: 1'b0};
          OP_DEC:  alu_req = '{a: va_q, b: 32'd1, sub: 1'b1};
          OP_ADD:  alu_req = '{a: va_q, b: vb_q, sub: 1'b0};
          OP_PUSH: alu_req = '{a: sp_q, b: 32'd4, sub: 1'b1};
          default: alu_req = '{a: va_q, b: vb_q, sub: 1'b1};
        endcase
      end
      S_XCHK: alu_req = '{a: waddr_q, b: 32'd3, sub: 1'b0};
      S_MST: begin
        mem_addr  = waddr_q[AW-1:0] + AW'(cnt_q[1:0]);
        mem_we    = 1'b1;
        mem_wdata = sword_q[31:24];
      end
      S_MLREQ: mem_addr = waddr_q[AW-1:0] + AW'(cnt_q[1:0]);
      S_WIP: begin
        rf_we = 1'b1;
        if ((op == OP_JMP) || ((op == OP_JEQ) && flags_q[0])) begin
          rf_wdata = jimm;
        end
      end
      S_WRA: begin
        rf_we   = 1'b1;
        rf_wsel = ra;
        case (op)
          OP_MOV:  rf_wdata = imm;
          OP_POP:  rf_wdata = word_q;
          OP_MOVR: rf_wdata = vb_q;
          default: rf_wdata = res_q;
        endcase
      end
      S_WSP: begin
        rf_rsel = SP_SEL;
        rf_we   = 1'b1;
        rf_wsel = SP_SEL;
        alu_req = '{a: rf_rd, b: 32'd4, sub: 1'b0};
        rf_wdata = (op == OP_PUSH) ? res_q : alu_res.sum[31:0];
      end
      default: rf_rsel = IP_SEL;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) begin
        rf_q[i] <= 32'd0;
      end
    end else if (rf_we) begin
      rf_q[rf_wsel] <= rf_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= S_CLR;
      clr_q            <= '0;
      cnt_q            <= '0;
      status_q         <= ST_RUN;
      flags_q          <= 3'd0;
      out_valid_o      <= 1'b0;
      read_value_o     <= 32'd0;
      ip_now_o         <= 32'd0;
      machine_status_o <= ST_RUN;
      cmp_flags_o      <= 3'd0;
    end else begin
      if (out_valid_o && !out_stall_i && (state_q != S_RESP)) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        S_CLR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(MEM_BYTES - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            case (mode_i)
              MODE_EXEC: begin
                rv_q <= 32'd0;
                if ((status_q == ST_RUN) && ({1'b0, rf_rd} < MEM_LIM)) begin
                  ip_q  <= rf_rd;
                  cnt_q <= 3'd0;
                  for (int i = 0; i < 6; i++) begin
                    buf_q[i] <= 8'd0;
                  end
                  state_q <= S_FREQ;
                end else begin
                  if (status_q == ST_RUN) begin
                    status_q <= ST_IPOOB;
                  end
                  state_q <= S_RESP;
                end
              end
              MODE_RDB: begin
                rv_q    <= 32'd0;
                state_q <= addr_ok ? S_RDW : S_RESP;
              end
              MODE_RDR: begin
                rv_q    <= rf_rd;
                state_q <= S_RESP;
              end
              default: begin
                rv_q    <= 32'd0;
                state_q <= S_RESP;
              end
            endcase
          end
        end
        S_RDW: begin
          rv_q    <= {24'd0, mem_rdata};
          state_q <= S_RESP;
        end
        S_FREQ: state_q <= S_FCAP;
        S_FCAP: begin
          buf_q[cnt_q] <= mem_rdata;
          if (cnt_q == 3'd0) begin
            len_q  <= flen;
            next_q <= ip_q + 32'(flen);
            if (mem_rdata > OP_MOVMR) begin
              status_q <= ST_BADOP;
              state_q  <= S_RESP;
            end else if (({1'b0, ip_q} + 33'(flen)) > MEM_LIM) begin
              status_q <= ST_IPOOB;
              state_q  <= S_RESP;
            end else if (flen == 3'd1) begin
              state_q <= S_RA;
            end else begin
              cnt_q   <= 3'd1;
              state_q <= S_FREQ;
            end
          end else if (cnt_q + 3'd1 == len_q) begin
            state_q <= S_RA;
          end else begin
            cnt_q   <= cnt_q + 3'd1;
            state_q <= S_FREQ;
          end
        end
        S_RA: begin
          va_q    <= rf_rd;
          state_q <= S_RB;
        end
        S_RB: begin
          vb_q    <= rf_rd;
          state_q <= S_RS;
        end
        S_RS: begin
          sp_q    <= rf_rd;
          state_q <= S_XALU;
        end
        S_XALU: begin
          res_q   <= alu_res.sum[31:0];
          cnt_q   <= 3'd0;
          case (op)
            OP_CMP: begin
              flags_q <= alu_res.eq ? FL_EQ : (alu_res.gt ? FL_GT : FL_LT);
              state_q <= S_WIP;
            end
            OP_PUSH: begin
              waddr_q <= alu_res.sum[31:0];
              sword_q <= jimm;
              state_q <= S_XCHK;
            end
            OP_POP: begin
              waddr_q <= sp_q;
              state_q <= S_XCHK;
            end
            OP_MOVM: begin
              waddr_q <= va_q;
              sword_q <= imm;
              state_q <= S_XCHK;
            end
            OP_MOVMR: begin
              waddr_q <= va_q;
              sword_q <= vb_q;
              state_q <= S_XCHK;
            end
            default: state_q <= S_WIP;
          endcase
        end
        S_XCHK: begin
          if (alu_res.sum >= MEM_LIM) begin
            status_q <= ST_ABORT;
            state_q  <= S_RESP;
          end else if (op == OP_POP) begin
            state_q <= S_MLREQ;
          end else begin
            state_q <= S_MST;
          end
        end
        S_MST: begin
          sword_q <= {sword_q[23:0], 8'd0};
          cnt_q   <= cnt_q + 3'd1;
          if (cnt_q == 3'd3) begin
            state_q <= S_WIP;
          end
        end
        S_MLREQ: state_q <= S_MLCAP;
        S_MLCAP: begin
          word_q <= {word_q[23:0], mem_rdata};
          cnt_q  <= cnt_q + 3'd1;
          state_q <= (cnt_q == 3'd3) ? S_WIP : S_MLREQ;
        end
        S_WIP: begin
          if (op == OP_STOP) begin
            status_q <= ST_STOP;
          end
          if (ra_write) begin
            state_q <= S_WRA;
          end else if (op == OP_PUSH) begin
            state_q <= S_WSP;
          end else begin
            state_q <= S_RESP;
          end
        end
        S_WRA: state_q <= (op == OP_POP) ? S_WSP : S_RESP;
        S_WSP: state_q <= S_RESP;
        S_RESP: begin
          if (!out_valid_o || !out_stall_i) begin
            out_valid_o      <= 1'b1;
            read_value_o     <= rv_q;
            ip_now_o         <= rf_rd;
            machine_status_o <= status_q;
            cmp_flags_o      <= flags_q;
            state_q          <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `BCCS_ASSERT(a_one_at_a_time, (in_valid_i && !in_stall_o) |=> in_stall_o, "request taken while busy")
  `BCCS_ASSERT(a_freeze_holds, (status_q != ST_RUN) |=> (status_q != ST_RUN), "frozen machine restarted")
  `BCCS_ASSERT_ALWAYS(a_no_result_in_clear, (state_q == S_CLR) |-> !out_valid_o, "result during clear pass")
  `BCCS_ASSERT(a_mem_write_states, mem_we |-> ((state_q == S_IDLE) || (state_q == S_CLR) || (state_q == S_MST)), "stray memory write")
  `BCCS_ASSERT(a_fault_no_reg_write, ($past(status_q) != ST_RUN) |-> !rf_we, "register written while frozen")

endmodule
`default_nettype wire
